### rtl/tmlc_pkg.sv
// ----------------------------------------------------------------------------
// tmlc_pkg
// Shared types, register codes and the level quantizer of the trimmed-mean
// light level classifier.
// ----------------------------------------------------------------------------
package tmlc_pkg;

    localparam int FILT_W    = 12;
    localparam int LEVEL_W   = 3;
    localparam int THR_W     = 12;
    localparam int NUM_THR   = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic [FILT_W-1:0] FILT_MAX = '1;

    // threshold register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_L1      = 3'd0,
        REG_THR_L2_BAND = 3'd1,
        REG_THR_L2      = 3'd2,
        REG_THR_L3_BAND = 3'd3,
        REG_THR_L3      = 3'd4,
        REG_THR_L4_BAND = 3'd5,
        REG_THR_L4      = 3'd6,
        REG_THR_L5      = 3'd7
    } t_reg_idx;

    // brightness level codes
    localparam logic [LEVEL_W-1:0] LVL_1 = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_2 = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_3 = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_4 = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_5 = 3'd4;

    typedef logic [THR_W-1:0] t_thr_arr [NUM_THR];

    localparam t_thr_arr THR_RESET = '{
        12'd64, 12'd128, 12'd256, 12'd512, 12'd768, 12'd1024, 12'd1536, 12'd2048
    };

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_FILL    = 7'b0000010,
        ST_SCAN    = 7'b0000100,
        ST_TRIM_MX = 7'b0001000,
        ST_TRIM_MN = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_CLASS   = 7'b1000000
    } t_state;

    // priority chain from the top threshold down, bands keep the last level
    function automatic logic [LEVEL_W-1:0] classify(
        input logic [FILT_W-1:0]  v,
        input logic [LEVEL_W-1:0] last,
        input t_thr_arr           thr
    );
        logic [LEVEL_W-1:0] lvl;
        if (v >= thr[REG_THR_L5]) begin
            lvl = LVL_5;
        end else if (v >= thr[REG_THR_L4]) begin
            lvl = (last >= LVL_5) ? LVL_5 : LVL_4;
        end else if (v >= thr[REG_THR_L4_BAND]) begin
            lvl = LVL_4;
        end else if (v >= thr[REG_THR_L3]) begin
            lvl = (last >= LVL_4) ? LVL_4 : LVL_3;
        end else if (v >= thr[REG_THR_L3_BAND]) begin
            lvl = LVL_3;
        end else if (v >= thr[REG_THR_L2]) begin
            lvl = (last >= LVL_3) ? LVL_3 : LVL_2;
        end else if (v >= thr[REG_THR_L2_BAND]) begin
            lvl = LVL_2;
        end else if (v >= thr[REG_THR_L1]) begin
            lvl = (last >= LVL_2) ? LVL_2 : LVL_1;
        end else begin
            lvl = LVL_1;
        end
        return lvl;
    endfunction

endpackage

### rtl/trimmed_mean_light_level_classifier.sv
// ----------------------------------------------------------------------------
// trimmed_mean_light_level_classifier
// Trimmed mean over a ring of light samples, quantized to five levels with
// hysteresis.
// ----------------------------------------------------------------------------
// One sample is taken per word; each gives one word of filtered value and
// level. The block handles one sample at a time and is busy meanwhile, so
// it takes no new sample until it is through with the last one. The ring is
// walked one entry per cycle through its single read port into the shared
// adder, which then takes off the largest and smallest entries, and the
// trimmed sum is divided by WINDOW-2 by a multiply with the constant
// reciprocal. The first sample after reset also fills every ring slot. A
// finished word waits in the output register while the next sample is
// taken; if it is still unread when the next result is ready, the block
// holds and takes no sample until it is read. Thresholds are written by
// index 0..7; the user must write them only while the block is idle, as
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module trimmed_mean_light_level_classifier #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [tmlc_pkg::FILT_W-1:0]     o_filtered,
    output logic [tmlc_pkg::LEVEL_W-1:0]    o_level,
    input  logic                            i_cfg_we,
    input  logic [tmlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmlc_pkg::THR_W-1:0]      i_cfg_data
);
    import tmlc_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIVISOR = WINDOW - 2;
    localparam int AW      = SUM_W + 1;
    localparam int EXT_W   = (SUM_W > FILT_W) ? SUM_W : FILT_W;
    localparam int DIV_SH  = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    t_state                 r_state, n_state;
    logic                   r_primed, n_primed;
    logic [IDX_W-1:0]       r_wslot, n_wslot;
    logic [LEVEL_W-1:0]     r_last_level, n_last_level;
    t_thr_arr               r_thr;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [SAMPLE_BITS-1:0] r_smp, n_smp;
    logic [SAMPLE_BITS-1:0] r_mx, n_mx;
    logic [SAMPLE_BITS-1:0] r_mn, n_mn;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_out_valid, n_out_valid;
    logic [FILT_W-1:0]      r_filtered, n_filtered;
    logic [LEVEL_W-1:0]     r_level, n_level;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic [SAMPLE_BITS-1:0] w_wr_data;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [AW-1:0]          w_alu_a, w_alu_b, w_alu_y;
    logic                   w_alu_sub;
    logic [PROD_W-1:0]      w_prod;
    logic [EXT_W-1:0]       w_sum_ext;
    logic [FILT_W-1:0]      w_filt;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign w_accept       = i_sample_valid && o_sample_ready;
    assign w_out_free     = !r_out_valid || i_result_ready;
    assign o_result_valid = r_out_valid;
    assign o_filtered     = r_filtered;
    assign o_level        = r_level;

    // ring write: direct on accept once primed, swept while filling
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_wslot;
        w_wr_data = i_sample;
        if (r_state == ST_FILL) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_idx[IDX_W-1:0];
            w_wr_data = r_smp;
        end else if (w_accept && r_primed) begin
            w_wr_en = 1'b1;
        end
    end

    assign w_rd_addr = (r_idx == CNT_W'(WINDOW)) ? '0 : r_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_ring[w_rd_addr];
    end

    // shared add/subtract unit
    always_comb begin
        w_alu_a   = AW'(r_sum);
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        unique case (r_state)
            ST_SCAN: begin
                w_alu_b = AW'(r_rd_data);
            end
            ST_TRIM_MX: begin
                w_alu_b   = AW'(r_mx);
                w_alu_sub = 1'b1;
            end
            ST_TRIM_MN: begin
                w_alu_b   = AW'(r_mn);
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_b = '0;
            end
        endcase
        w_alu_y = w_alu_a + (w_alu_sub ? ~w_alu_b : w_alu_b) + AW'(w_alu_sub);
    end

    // reciprocal of WINDOW-2, exact over the whole sum range
    assign w_prod = PROD_W'(r_sum) * RECIP;

    // saturate the quotient to the output width
    assign w_sum_ext = EXT_W'(r_sum);
    assign w_filt    = (w_sum_ext > EXT_W'(FILT_MAX)) ? FILT_MAX : w_sum_ext[FILT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_primed     = r_primed;
        n_wslot      = r_wslot;
        n_last_level = r_last_level;
        n_idx        = r_idx;
        n_smp        = r_smp;
        n_mx         = r_mx;
        n_mn         = r_mn;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_filtered   = r_filtered;
        n_level      = r_level;

        if (r_out_valid && i_result_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_smp   = i_sample;
                    n_idx   = '0;
                    n_sum   = '0;
                    n_mx    = '0;
                    n_mn    = '1;
                    n_wslot = (r_wslot == IDX_W'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                    n_state = r_primed ? ST_SCAN : ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_idx == CNT_W'(WINDOW - 1)) begin
                    n_idx    = '0;
                    n_primed = 1'b1;
                    n_state  = ST_SCAN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SCAN: begin
                // read data is registered behind the address, so index 0 brings no data yet
                if (r_idx != '0) begin
                    n_sum = w_alu_y[SUM_W-1:0];
                    n_mx  = (r_rd_data > r_mx) ? r_rd_data : r_mx;
                    n_mn  = (r_rd_data < r_mn) ? r_rd_data : r_mn;
                end
                if (r_idx == CNT_W'(WINDOW)) begin
                    n_state = ST_TRIM_MX;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TRIM_MX: begin
                n_sum   = w_alu_y[SUM_W-1:0];
                n_state = ST_TRIM_MN;
            end
            ST_TRIM_MN: begin
                n_sum   = w_alu_y[SUM_W-1:0];
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_sum   = SUM_W'(w_prod >> DIV_SH);
                n_state = ST_CLASS;
            end
            ST_CLASS: begin
                if (w_out_free) begin
                    n_filtered   = w_filt;
                    n_level      = classify(w_filt, r_last_level, r_thr);
                    n_last_level = n_level;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_primed     <= 1'b0;
            r_wslot      <= '0;
            r_last_level <= LVL_2;
            r_out_valid  <= 1'b0;
            r_thr        <= THR_RESET;
        end else begin
            r_state      <= n_state;
            r_primed     <= n_primed;
            r_wslot      <= n_wslot;
            r_last_level <= n_last_level;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_thr[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_smp      <= n_smp;
        r_mx       <= n_mx;
        r_mn       <= n_mn;
        r_sum      <= n_sum;
        r_filtered <= n_filtered;
        r_level    <= n_level;
    end

endmodule

### tb/tb_trimmed_mean_light_level_classifier.sv
// ----------------------------------------------------------------------------
// tb_trimmed_mean_light_level_classifier
// Drives light samples through the trimmed-mean level classifier and checks
// every filtered value and level against an in-bench predictor of the ring,
// the trimmed mean and the hysteresis quantizer, under several threshold
// settings and with random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_light_level_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import tmlc_pkg::*;

    localparam int WIN            = 8;
    localparam int SAMPLE_W       = 12;
    localparam int SETTLE_CYCLES  = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int RX_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [FILT_W-1:0]  filtered;
        logic [LEVEL_W-1:0] level;
    } t_reading;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_sample_valid = 1'b0;
    logic                 o_sample_ready;
    logic [SAMPLE_W-1:0]  i_sample       = '0;
    logic                 o_result_valid;
    logic                 i_result_ready = 1'b0;
    logic [FILT_W-1:0]    o_filtered;
    logic [LEVEL_W-1:0]   o_level;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [THR_W-1:0]     i_cfg_data     = '0;

    // predictor state
    logic [SAMPLE_W-1:0] sample_hist [WIN];
    int                  hist_wr     = 0;
    bit                  hist_primed = 1'b0;
    logic [LEVEL_W-1:0]  prev_level  = LVL_2;
    logic [THR_W-1:0]    thr_model [NUM_THR];
    logic [THR_W-1:0]    thr_plan  [NUM_THR];

    t_reading pending_readings [$];
    int       mismatch_count = 0;
    int       tx_idle_pct    = 0;
    int       rx_idle_pct    = 0;
    int       rx_hold_req    = 0;
    int       rx_hold_seen   = 0;
    int       rx_hold_left   = 0;

    trimmed_mean_light_level_classifier #(
        .WINDOW      (WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_filtered     (o_filtered),
        .o_level        (o_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            i_result_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: filtered %0d level %0d", o_filtered, o_level);
            end else begin
                want = pending_readings.pop_front();
                if (o_filtered !== want.filtered) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("filtered mismatch: expected %0d actual %0d",
                                 want.filtered, o_filtered);
                end
                if (o_level !== want.level) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("level mismatch: expected %0d actual %0d (filtered %0d)",
                                 want.level, o_level, want.filtered);
                end
            end
        end
    end

    // walk the thresholds from the top; odd ranks are firm edges, even ranks
    // open a band that keeps the upper level if we were already there
    function automatic logic [LEVEL_W-1:0] quantize(input logic [FILT_W-1:0] v,
                                                    input logic [LEVEL_W-1:0] prev);
        int upper;
        for (int k = NUM_THR - 1; k >= 0; k--) begin
            if (v >= thr_model[k]) begin
                upper = LVL_1 + k / 2 + 1;
                if (k % 2 == 1 || prev >= upper)
                    return LEVEL_W'(upper);
                return LEVEL_W'(upper - 1);
            end
        end
        return LVL_1;
    endfunction

    task automatic predict_reading(input logic [SAMPLE_W-1:0] s);
        int       total;
        int       hi;
        int       lo;
        t_reading r;
        if (!hist_primed) begin
            foreach (sample_hist[i]) sample_hist[i] = s;
            hist_primed = 1'b1;
        end else begin
            sample_hist[hist_wr] = s;
        end
        hist_wr = (hist_wr + 1) % WIN;
        total = 0;
        hi = sample_hist[0];
        lo = sample_hist[0];
        foreach (sample_hist[i]) begin
            total += sample_hist[i];
            if (sample_hist[i] > hi) hi = sample_hist[i];
            if (sample_hist[i] < lo) lo = sample_hist[i];
        end
        total = (total - hi - lo) / (WIN - 2);
        if (total > FILT_MAX) total = FILT_MAX;
        prev_level = quantize(total[FILT_W-1:0], prev_level);
        r.filtered = total[FILT_W-1:0];
        r.level    = prev_level;
        pending_readings.push_back(r);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        predict_reading(s);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_sample_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic settle();
        i_sample_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_thresholds();
        for (int i = 0; i < NUM_THR; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= thr_plan[i];
            @(posedge i_clk);
            thr_model[i] = thr_plan[i];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic plan_ordered(input int step_max);
        int edge_val;
        edge_val = $urandom_range(step_max);
        for (int i = 0; i < NUM_THR; i++) begin
            thr_plan[i] = (edge_val > FILT_MAX) ? FILT_MAX : THR_W'(edge_val);
            edge_val += $urandom_range(step_max);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] wobble(input int center, input int span);
        int v;
        v = center + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > FILT_MAX) v = FILT_MAX;
        return SAMPLE_W'(v);
    endfunction

    // mostly runs that settle near one threshold, some noise and extremes
    task automatic send_mix(input int n);
        int                  sent;
        int                  kind;
        int                  run_len;
        logic [SAMPLE_W-1:0] center;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                send_sample(SAMPLE_W'($urandom_range(FILT_MAX)));
                sent++;
            end else if (kind < 16) begin
                send_sample($urandom_range(1) ? FILT_MAX : '0);
                sent++;
            end else begin
                center  = wobble(thr_model[$urandom_range(NUM_THR - 1)], 8);
                run_len = $urandom_range(3, 10);
                repeat (run_len) begin
                    send_sample(wobble(center, 3));
                    sent++;
                end
            end
        end
    endtask

    // first word fills the ring, then a staircase down from 1700 to 30 and back up
    task automatic run_directed();
        int steps [25] = '{4095, 0, 12'hAAA, 12'h555,
                           1700, 1700, 1700, 1700, 1100, 1100, 1100,
                           600, 600, 600, 200, 200, 200, 100, 100, 100,
                           30, 30, 1700, 1700, 4095};
        set_idle(17, 48);
        foreach (steps[i]) send_sample(SAMPLE_W'(steps[i]));
        settle();
    endtask

    task automatic run_threshold_sweep();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: thr_plan = THR_RESET;
                1: foreach (thr_plan[i]) thr_plan[i] = '0;
                2: foreach (thr_plan[i]) thr_plan[i] = FILT_MAX;
                3: plan_ordered(600);
                4: foreach (thr_plan[i]) thr_plan[i] = THR_W'($urandom_range(FILT_MAX));
                default: plan_ordered(40);
            endcase
            if (p < 2) set_idle(17, 48);
            else if (p < 4) set_idle(48, 17);
            else set_idle(0, 0);
            program_thresholds();
            send_mix(150);
            settle();
        end
    endtask

    // receiver stalls long enough that the input side backs up
    task automatic run_backpressure();
        set_idle(0, 0);
        rx_hold_req++;
        send_mix(24);
        settle();
    endtask

    task automatic run_random_settings();
        for (int round = 0; round < 6; round++) begin
            if (round % 2 == 0)
                plan_ordered(int'($urandom_range(20, 700)));
            else
                foreach (thr_plan[i]) thr_plan[i] = THR_W'($urandom_range(FILT_MAX));
            case (round % 3)
                0: set_idle(17, 48);
                1: set_idle(48, 17);
                default: set_idle(0, 0);
            endcase
            program_thresholds();
            send_mix(150);
            settle();
        end
    endtask

    initial begin
        thr_model = THR_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_threshold_sweep();
        run_backpressure();
        run_random_settings();
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
